// File: hw/rtl/rrb_pkg.sv
// Shared types and constants for the RAID-5 block read and rebuild unit.
// Used by every module under hw/rtl; depends on nothing else.
package rrb_pkg;

    localparam int ADDR_W   = 16;  // block address width
    localparam int DATA_W   = 32;  // disk word width
    localparam int REG_W    = 13;  // widest configuration register
    localparam int CFG_IDX_W = 2;
    localparam int N_W      = 7;   // disk count in use, up to 64
    localparam int WPD_W    = 21;  // words per disk in use, up to 2^20
    localparam int OFF_W    = 30;  // mapped offset before range check

    localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_WORDS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORDS_PER_DISK = 2'd2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [4:0]       RST_DISK_COUNT     = 5'd3;
    localparam logic [REG_W-1:0] RST_STRIPE_WORDS   = 13'd1;
    localparam logic [REG_W-1:0] RST_WORDS_PER_DISK = 13'd4096;
    localparam logic [REG_W-1:0] STRIPE_MAX         = 13'd4096;

    typedef struct packed {
        logic              kind;
        logic [3:0]        disk_index;
        logic [11:0]       word_offset;
        logic [DATA_W-1:0] load_data;
        logic [ADDR_W-1:0] block_address;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              available;
    } t_out;

    typedef enum logic [1:0] {
        DIV_A_BY_S  = 2'd0,
        DIV_B_BY_N1 = 2'd1,
        DIV_K_BY_N  = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     load_wr;
        logic     lat_a;
        logic     cap;
        logic     div_start;
        t_div_sel div_sel;
        logic     lat_b;
        logic     lat_k;
        logic     lat_kmn;
        logic     map;
        logic     rd_c;
        logic     walk_clr;
        logic     walk_issue;
        logic     emit;
        logic     emit_ok;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic cap_over;
        logic off_over;
        logic c_present;
        logic others_ok;
        logic walk_last;
        logic out_free;
    } t_sts;

endpackage

// File: hw/rtl/rrb_div.sv
// Restoring divider, one quotient bit per cycle, for 16-bit operands.
// Uses rrb_pkg for widths.
module rrb_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rrb_pkg::ADDR_W-1:0] i_dividend,
    input  logic [rrb_pkg::ADDR_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [rrb_pkg::ADDR_W-1:0] o_quot,
    output logic [rrb_pkg::ADDR_W-1:0] o_rem
);
    localparam int W = rrb_pkg::ADDR_W;

    logic [W-1:0]         r_q, r_r, r_dvs;
    logic [$clog2(W):0]   r_cnt;
    logic                 r_busy, r_done;
    logic [W:0]           shifted, trial;
    logic                 ge;

    assign shifted = {r_r, r_q[W-1]};
    assign trial   = shifted - {1'b0, r_dvs};
    assign ge      = !trial[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= ($clog2(W)+1)'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ($clog2(W)+1)'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_q   <= i_dividend;
            r_r   <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_r <= ge ? trial[W-1:0] : shifted[W-1:0];
            r_q <= {r_q[W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

// File: hw/rtl/rrb_datapath.sv
// Datapath: configuration, disk word memory, present mask, address mapping,
// rebuild XOR accumulator and result register. Uses rrb_pkg and rrb_div.
module rrb_datapath #(
    parameter int MAX_DISKS  = 16,
    parameter int DISK_WORDS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rrb_pkg::REG_W-1:0]     i_cfg_wdata,
    input  rrb_pkg::t_in                  i_in,
    input  rrb_pkg::t_cmd                 i_cmd,
    output rrb_pkg::t_sts                 o_sts,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output rrb_pkg::t_out                 o_out
);
    localparam int N_W   = rrb_pkg::N_W;
    localparam int WPD_W = rrb_pkg::WPD_W;
    localparam int OFF_W = rrb_pkg::OFF_W;
    localparam int A_W   = rrb_pkg::ADDR_W;
    localparam int DW    = $clog2(MAX_DISKS);
    localparam int OW    = (DISK_WORDS > 1) ? $clog2(DISK_WORDS) : 1;
    localparam int MW    = DW + OW;
    localparam logic [N_W-1:0]   NMAX   = N_W'(MAX_DISKS);
    localparam logic [WPD_W-1:0] DWORDS = WPD_W'(DISK_WORDS);

    // configuration
    logic [4:0]                  r_dc;
    logic [rrb_pkg::REG_W-1:0]   r_sw, r_wpd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc  <= rrb_pkg::RST_DISK_COUNT;
            r_sw  <= rrb_pkg::RST_STRIPE_WORDS;
            r_wpd <= rrb_pkg::RST_WORDS_PER_DISK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rrb_pkg::CFG_DISK_COUNT:     r_dc  <= i_cfg_wdata[4:0];
                rrb_pkg::CFG_STRIPE_WORDS:   r_sw  <= i_cfg_wdata;
                rrb_pkg::CFG_WORDS_PER_DISK: r_wpd <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // values in use, saturated to their bounds
    logic [N_W-1:0]            n, dc_ext;
    logic [rrb_pkg::REG_W-1:0] s;
    logic [WPD_W-1:0]          wpd, wpd_ext;

    assign dc_ext  = {2'b00, r_dc};
    assign wpd_ext = {8'd0, r_wpd};
    always_comb begin
        n = dc_ext;
        if (dc_ext < N_W'(2)) n = N_W'(2);
        else if (dc_ext > NMAX) n = NMAX;
        s = r_sw;
        if (r_sw == '0) s = 13'd1;
        else if (r_sw > rrb_pkg::STRIPE_MAX) s = rrb_pkg::STRIPE_MAX;
        wpd = wpd_ext;
        if (wpd_ext == '0) wpd = WPD_W'(1);
        else if (wpd_ext > DWORDS) wpd = DWORDS;
    end

    // disk store and present mask
    logic [rrb_pkg::DATA_W-1:0] mem [MAX_DISKS << OW];
    logic [MAX_DISKS-1:0]       r_present;
    logic [N_W-1:0]             di_ext;
    logic [WPD_W-1:0]           wo_ext;
    logic                       wr_ok;
    logic [MW-1:0]              wr_addr, rd_addr;
    logic [rrb_pkg::DATA_W-1:0] r_rdata;

    assign di_ext  = {3'b000, i_in.disk_index};
    assign wo_ext  = {9'd0, i_in.word_offset};
    assign wr_ok   = i_cmd.load_wr && (di_ext < NMAX) && (wo_ext < DWORDS);
    assign wr_addr = {di_ext[DW-1:0], wo_ext[OW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (wr_ok) begin
            r_present[di_ext[DW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) mem[wr_addr] <= i_in.load_data;
    end

    // address mapping
    logic [A_W-1:0]   r_a, r_d, r_k, r_r2, r_kmn;
    logic [27:0]      r_prod;
    logic [OFF_W-1:0] r_off;
    logic [DW-1:0]    r_c, r_i;
    logic [A_W-1:0]   dvd, dvs, quot, rem;
    logic             div_done;
    logic [N_W:0]     c_raw, c_fix;

    always_comb begin
        dvd = r_a;
        dvs = {3'b000, s};
        unique case (i_cmd.div_sel)
            rrb_pkg::DIV_A_BY_S: begin
                dvd = r_a;
                dvs = {3'b000, s};
            end
            rrb_pkg::DIV_B_BY_N1: begin
                dvd = quot;
                dvs = {9'd0, n - N_W'(1)};
            end
            rrb_pkg::DIV_K_BY_N: begin
                dvd = quot;
                dvs = {9'd0, n};
            end
            default: ;
        endcase
    end

    rrb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // parity disk is n-1-(k mod n); data disk follows it, wrapping round
    assign c_raw = {1'b0, n} - {1'b0, r_kmn[N_W-1:0]} + {1'b0, r_r2[N_W-1:0]};
    assign c_fix = (c_raw >= {1'b0, n}) ? c_raw - {1'b0, n} : c_raw;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_a)   r_a <= i_in.block_address;
        if (i_cmd.cap)     r_prod <= 28'({7'd0, wpd} * {21'd0, n - N_W'(1)});
        if (i_cmd.lat_b)   r_d <= rem;
        if (i_cmd.lat_k) begin
            r_k  <= quot;
            r_r2 <= rem;
        end
        if (i_cmd.lat_kmn) r_kmn <= rem;
        if (i_cmd.map) begin
            r_off <= OFF_W'({14'd0, r_k} * {17'd0, s}) + {14'd0, r_d};
            r_c   <= c_fix[DW-1:0];
        end
    end

    // rebuild walk: reads are registered, so accumulate in the cycle after issue
    logic                       r_take;
    logic [rrb_pkg::DATA_W-1:0] r_acc;
    logic                       others_ok;

    assign rd_addr = {(i_cmd.rd_c ? r_c : r_i), r_off[OW-1:0]};

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_take <= 1'b0;
        end else begin
            r_take <= i_cmd.rd_c || (i_cmd.walk_issue && (r_i != r_c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_clr) begin
            r_acc <= '0;
            r_i   <= '0;
        end else begin
            if (r_take) r_acc <= r_acc ^ r_rdata;
            if (i_cmd.walk_issue) r_i <= r_i + 1'b1;
        end
    end

    always_comb begin
        others_ok = 1'b1;
        for (int j = 0; j < MAX_DISKS; j++) begin
            if ((N_W'(j) < n) && (DW'(j) != r_c) && !r_present[j]) others_ok = 1'b0;
        end
    end

    // result register
    logic          r_ovld;
    rrb_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovld <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.read_data <= i_cmd.emit_ok ? r_acc : '0;
            r_out.available <= i_cmd.emit_ok;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out       = r_out;

    assign o_sts.div_done  = div_done;
    assign o_sts.cap_over  = {12'd0, r_a} >= r_prod;
    assign o_sts.off_over  = r_off >= OFF_W'(wpd);
    assign o_sts.c_present = r_present[r_c];
    assign o_sts.others_ok = others_ok;
    assign o_sts.walk_last = {{(N_W-DW){1'b0}}, r_i} == (n - N_W'(1));
    assign o_sts.out_free  = !r_ovld || !i_out_stall;
endmodule

// File: hw/rtl/rrb_ctrl.sv
// Controller state machine: sequences load writes, the three divisions,
// the mapping, the rebuild walk and the result hand-off. Uses rrb_pkg.
module rrb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_kind,
    output logic          o_in_stall,
    input  rrb_pkg::t_sts i_sts,
    output rrb_pkg::t_cmd o_cmd
);
    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_CAP  = 12'b0000_0000_0010,
        S_CMP  = 12'b0000_0000_0100,
        S_D1   = 12'b0000_0000_1000,
        S_D2   = 12'b0000_0001_0000,
        S_D3   = 12'b0000_0010_0000,
        S_MAP  = 12'b0000_0100_0000,
        S_CHK  = 12'b0000_1000_0000,
        S_WALK = 12'b0001_0000_0000,
        S_WEND = 12'b0010_0000_0000,
        S_OUT  = 12'b0100_0000_0000,
        S_FAIL = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_in_kind == rrb_pkg::KIND_QUERY)) begin
                    o_cmd.lat_a = 1'b1;
                    n_state     = S_CAP;
                end else if (i_in_valid) begin
                    o_cmd.load_wr = 1'b1;
                end
            end
            S_CAP: begin
                o_cmd.cap = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (i_sts.cap_over) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = rrb_pkg::DIV_A_BY_S;
                    n_state         = S_D1;
                end
            end
            S_D1: begin
                if (i_sts.div_done) begin
                    o_cmd.lat_b     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = rrb_pkg::DIV_B_BY_N1;
                    n_state         = S_D2;
                end
            end
            S_D2: begin
                if (i_sts.div_done) begin
                    o_cmd.lat_k     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = rrb_pkg::DIV_K_BY_N;
                    n_state         = S_D3;
                end
            end
            S_D3: begin
                if (i_sts.div_done) begin
                    o_cmd.lat_kmn = 1'b1;
                    n_state       = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                priority if (i_sts.off_over) begin
                    n_state = S_FAIL;
                end else if (i_sts.c_present) begin
                    o_cmd.walk_clr = 1'b1;
                    o_cmd.rd_c     = 1'b1;
                    n_state        = S_WEND;
                end else if (i_sts.others_ok) begin
                    o_cmd.walk_clr = 1'b1;
                    n_state        = S_WALK;
                end else begin
                    n_state = S_FAIL;
                end
            end
            S_WALK: begin
                o_cmd.walk_issue = 1'b1;
                if (i_sts.walk_last) n_state = S_WEND;
            end
            S_WEND: n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_ok = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_FAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
endmodule

// File: hw/rtl/raid5_block_read_rebuild_unit.sv
// RAID-5 block read and rebuild unit, left-symmetric layout.
// Input channel (i_in_valid / o_in_stall, payload i_in) carries load and
// query requests; output channel (o_out_valid / i_out_stall, payload o_out)
// carries one result per query. A request is taken on a rising edge with
// valid high and stall low. Loads within the store bounds write one disk
// word and mark the disk present; the next request may follow at once.
// A query runs one request at a time: capacity check, three divisions of
// 16 quotient steps each on a shared restoring divider (address by strip
// size, strip by data disks, stripe by disk count), mapping, then either
// one memory read or a walk reading each of the n disks at the offset,
// one memory read port a cycle. A failed capacity or offset check, or a
// missing disk that cannot be rebuilt, gives a result with available low.
// The result sits in an output register; the next request is taken while
// it waits. A stalled result holds until taken, and a query finishing
// meanwhile waits for the register to drain. Synchronous active-low reset
// clears the present mask, restores the register defaults (3 disks,
// 1 word strips, 4096 words per disk) and empties the output; stored words
// are undefined until written. Configuration writes go straight to the
// registers on i_cfg_we; they are to be made only while the unit is idle,
// which the unit itself does not enforce.
module raid5_block_read_rebuild_unit #(
    parameter int MAX_DISKS  = 16,
    parameter int DISK_WORDS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rrb_pkg::REG_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  rrb_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output rrb_pkg::t_out                 o_out
);
    rrb_pkg::t_cmd cmd;
    rrb_pkg::t_sts sts;

    rrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in.kind),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rrb_datapath #(
        .MAX_DISKS  (MAX_DISKS),
        .DISK_WORDS (DISK_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );
endmodule
